/* hdl/eba_pkg.sv */
// ----------------------------------------------------------------------------
// eba_pkg
// Shared types and constants for the executable basename allowlist check.
// ----------------------------------------------------------------------------
package eba_pkg;

   // Storage sizes fixed by the field widths
   localparam int NAME_STORE  = 15;   // collected name bytes
   localparam int SLOT_STORE  = 64;   // slots reachable by a 6-bit slot field
   localparam int SLOT_WIDTH  = 6;
   localparam int COUNT_WIDTH = 4;
   localparam int KEY_WIDTH   = 64;

   // Character constants
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CASE_OFFSET  = 8'd32;

   // Request kinds
   localparam logic KIND_PATH_BYTE  = 1'b0;
   localparam logic KIND_SLOT_WRITE = 1'b1;

   // Token that moves down the cell chain, one cell per cycle while the chain advances
   typedef struct packed {
      logic                   valid;
      logic                   is_write;
      logic [SLOT_WIDTH-1:0]  slot;
      logic [KEY_WIDTH-1:0]   key_low;
      logic [KEY_WIDTH-1:0]   key_high;
      logic                   entry_valid;
      logic                   hit;
      logic [COUNT_WIDTH-1:0] name_length;
   } token_type;

endpackage

/* hdl/eba_if.sv */
// ----------------------------------------------------------------------------
// eba_if
// Valid/ready channels for path/slot requests and verdict responses.
// ----------------------------------------------------------------------------
interface eba_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  path_char;
   logic [5:0]  entry_slot;
   logic [63:0] entry_low;
   logic [63:0] entry_high;
   logic        entry_valid;

   modport source (output valid, kind, path_char, entry_slot, entry_low, entry_high,
                   entry_valid, input ready);
   modport sink   (input valid, kind, path_char, entry_slot, entry_low, entry_high,
                   entry_valid, output ready);
endinterface

interface eba_rsp_if;
   logic       valid;
   logic       ready;
   logic       allowed;
   logic [3:0] name_length;

   modport source (output valid, allowed, name_length, input ready);
   modport sink   (input valid, allowed, name_length, output ready);
endinterface

/* hdl/eba_name_collect.sv */
// ----------------------------------------------------------------------------
// eba_name_collect
// Builds the lowercased basename from path bytes and tracks the byte position.
// ----------------------------------------------------------------------------
module eba_name_collect #(
   parameter int SLASH_SCAN_LIMIT = 256,
   parameter int NAME_MAX_BYTES   = 15
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            byte_accept,  // path byte request taken
   input  logic [7:0]                      path_char,
   output logic [eba_pkg::KEY_WIDTH-1:0]   key_low,
   output logic [eba_pkg::KEY_WIDTH-1:0]   key_high,
   output logic [eba_pkg::COUNT_WIDTH-1:0] name_count
);

   localparam int PosWidth = $clog2(SLASH_SCAN_LIMIT + 1);
   localparam int StoreBits = eba_pkg::NAME_STORE * 8;

   logic [eba_pkg::NAME_STORE-1:0][7:0]  name_ff, name_in;
   logic [eba_pkg::COUNT_WIDTH-1:0]      count_ff, count_in;
   logic [PosWidth-1:0]                  pos_ff, pos_in;
   logic [StoreBits-1:0]                 name_flat;
   logic                                 pos_early;
   logic [7:0]                           lower_char;

   assign pos_early = pos_ff < PosWidth'(SLASH_SCAN_LIMIT);

   // A-Z only are folded to lowercase
   always_comb begin
      lower_char = path_char;
      if (path_char >= eba_pkg::CHAR_UPPER_A && path_char <= eba_pkg::CHAR_UPPER_Z) begin
         lower_char = path_char + eba_pkg::CASE_OFFSET;
      end
   end

   // Next name, count and position for an accepted path byte
   always_comb begin
      name_in  = name_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      if (byte_accept) begin
         if (path_char == eba_pkg::CHAR_NUL) begin
            name_in  = '0;
            count_in = '0;
            pos_in   = '0;
         end else begin
            if (path_char == eba_pkg::CHAR_SLASH && pos_early) begin
               name_in  = '0;
               count_in = '0;
            end else if (count_ff < eba_pkg::COUNT_WIDTH'(NAME_MAX_BYTES) &&
                         count_ff < eba_pkg::COUNT_WIDTH'(eba_pkg::NAME_STORE)) begin
               for (int i = 0; i < eba_pkg::NAME_STORE; i++) begin
                  if (count_ff == eba_pkg::COUNT_WIDTH'(i)) begin
                     name_in[i] = lower_char;
                  end
               end
               count_in = count_ff + 1'b1;
            end
            if (pos_early) begin
               pos_in = pos_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_ff  <= '0;
         count_ff <= '0;
         pos_ff   <= '0;
      end else begin
         name_ff  <= name_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
      end
   end

   // Zero padded 16-byte key, byte 0 in the low bits
   assign name_flat  = name_ff;
   assign key_low    = name_flat[eba_pkg::KEY_WIDTH-1:0];
   assign key_high   = {8'h00, name_flat[StoreBits-1:eba_pkg::KEY_WIDTH]};
   assign name_count = count_ff;

endmodule

/* hdl/eba_cell.sv */
// ----------------------------------------------------------------------------
// eba_cell
// One allowlist slot: holds a key, captures its own slot writes and folds its
// match into each passing lookup token.
// ----------------------------------------------------------------------------
module eba_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  eba_pkg::token_type token_in,
   output eba_pkg::token_type token_out
);

   logic [eba_pkg::KEY_WIDTH-1:0] key_low_ff, key_high_ff;
   logic                          used_ff;
   eba_pkg::token_type            token_ff, token_in_next;
   logic                          slot_hit, key_match;

   assign slot_hit  = token_in.valid && token_in.is_write &&
                      token_in.slot == eba_pkg::SLOT_WIDTH'(CELL_INDEX);
   assign key_match = used_ff && key_low_ff == token_in.key_low &&
                      key_high_ff == token_in.key_high;

   // Lookups pick up this slot's match on the way through
   always_comb begin
      token_in_next = token_in;
      if (!token_in.is_write && key_match) begin
         token_in_next.hit = 1'b1;
      end
   end

   // Slot contents; an unused slot never matches, so the key needs no reset
   always_ff @(posedge clock) begin
      if (advance && slot_hit) begin
         key_low_ff  <= token_in.key_low;
         key_high_ff <= token_in.key_high;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else if (advance && slot_hit) begin
         used_ff <= token_in.entry_valid;
      end
   end

   // Token stage to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= '0;
      end else if (advance) begin
         token_ff <= token_in_next;
      end
   end

   assign token_out = token_ff;

endmodule

/* hdl/exec_basename_allowlist_check.sv */
// ----------------------------------------------------------------------------
// exec_basename_allowlist_check
// Checks a streamed program path's basename against a slot allowlist.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request per handshake. kind 0 is a path byte; a zero byte
//   ends the path and triggers a lookup. kind 1 writes (or, with entry_valid
//   low, removes) allowlist slot entry_slot; slots at or beyond TABLE_ENTRIES
//   are ignored. Slot writes and path bytes give no response.
//   rsp returns one verdict per path: allowed and the basename length.
//   Throughput: one request per cycle while req.ready is high. A terminator's
//   lookup token walks the chain of slot cells, one cell per cycle while the
//   chain advances, and its verdict is then registered onto rsp.
//   Requests stay in order through the chain, so a write is seen by every
//   later lookup.
//   Reset (synchronous) empties the table and clears the name and position.
//   When rsp stalls with a verdict held, the chain keeps moving until the
//   next lookup reaches its end; then req.ready drops until rsp is taken.
// ----------------------------------------------------------------------------
module exec_basename_allowlist_check #(
   parameter int TABLE_ENTRIES    = 64,
   parameter int SLASH_SCAN_LIMIT = 256,
   parameter int NAME_MAX_BYTES   = 15
) (
   input  logic       clock,
   input  logic       reset,
   eba_req_if.sink    req,
   eba_rsp_if.source  rsp
);

   localparam int CellCount = (TABLE_ENTRIES < eba_pkg::SLOT_STORE) ?
                              TABLE_ENTRIES : eba_pkg::SLOT_STORE;

   eba_pkg::token_type              chain [0:CellCount];
   eba_pkg::token_type              head_token;
   logic                            advance, accept, byte_accept;
   logic [eba_pkg::KEY_WIDTH-1:0]   name_low, name_high;
   logic [eba_pkg::COUNT_WIDTH-1:0] name_count;
   logic                            tail_lookup;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            allowed_ff, allowed_in;
   logic [eba_pkg::COUNT_WIDTH-1:0] length_ff, length_in;

   // Chain moves unless a finished lookup would overwrite an unread verdict
   assign tail_lookup = chain[CellCount].valid && !chain[CellCount].is_write;
   assign advance     = !(tail_lookup && rsp_valid_ff && !rsp.ready);
   assign req.ready   = advance;
   assign accept      = req.valid && advance;
   assign byte_accept = accept && req.kind == eba_pkg::KIND_PATH_BYTE;

   eba_name_collect #(
      .SLASH_SCAN_LIMIT (SLASH_SCAN_LIMIT),
      .NAME_MAX_BYTES   (NAME_MAX_BYTES)
   ) u_name (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .path_char   (req.path_char),
      .key_low     (name_low),
      .key_high    (name_high),
      .name_count  (name_count)
   );

   // Chain head: slot writes and terminator lookups become tokens
   always_comb begin
      head_token             = '0;
      head_token.is_write    = req.kind == eba_pkg::KIND_SLOT_WRITE;
      head_token.slot        = req.entry_slot;
      head_token.entry_valid = req.entry_valid;
      head_token.name_length = name_count;
      if (req.kind == eba_pkg::KIND_SLOT_WRITE) begin
         head_token.valid    = accept;
         head_token.key_low  = req.entry_low;
         head_token.key_high = req.entry_high;
      end else begin
         head_token.valid    = byte_accept && req.path_char == eba_pkg::CHAR_NUL;
         head_token.key_low  = name_low;
         head_token.key_high = name_high;
      end
   end

   assign chain[0] = head_token;

   // Row of slot cells
   for (genvar g = 0; g < CellCount; g++) begin : g_cell
      eba_cell #(
         .CELL_INDEX (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .token_in  (chain[g]),
         .token_out (chain[g+1])
      );
   end

   // Verdict output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      allowed_in   = allowed_ff;
      length_in    = length_ff;
      if (advance && tail_lookup) begin
         rsp_valid_in = 1'b1;
         allowed_in   = chain[CellCount].hit;
         length_in    = chain[CellCount].name_length;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      allowed_ff <= allowed_in;
      length_ff  <= length_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.allowed     = allowed_ff;
   assign rsp.name_length = length_ff;

endmodule

/* tb/sv/eba_verdict_checker.sv */
// ----------------------------------------------------------------------------
// eba_verdict_checker
// Watches the request and response channels of the basename allowlist check,
// tracks the collected name, byte position and allowlist table, and compares
// every verdict with the oldest one predicted.
// ----------------------------------------------------------------------------
module eba_verdict_checker #(
   parameter int TABLE_ENTRIES    = 64,
   parameter int SLASH_SCAN_LIMIT = 256,
   parameter int NAME_MAX_BYTES   = 15
) (
   input  logic clock,
   input  logic reset,
   eba_req_if   req_mon,
   eba_rsp_if   rsp_mon,
   output int   failures,
   output int   verdicts_pending,
   output int   verdicts_checked,
   output int   verdicts_allowed
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic                            allowed;
      logic [eba_pkg::COUNT_WIDTH-1:0] name_length;
   } verdict_type;

   // Shadow copy of the block state
   logic [7:0]                      name_buf [eba_pkg::NAME_STORE];
   logic [eba_pkg::COUNT_WIDTH-1:0] name_len;
   logic [8:0]                      path_pos;
   logic [eba_pkg::KEY_WIDTH-1:0]   key_lo   [eba_pkg::SLOT_STORE];
   logic [eba_pkg::KEY_WIDTH-1:0]   key_hi   [eba_pkg::SLOT_STORE];
   logic                            slot_used[eba_pkg::SLOT_STORE];

   verdict_type verdicts_due[$];

   function automatic void clear_name();
      for (int i = 0; i < eba_pkg::NAME_STORE; i++) name_buf[i] = 8'h00;
      name_len = '0;
   endfunction

   // Pad the name to 16 bytes and search every slot in use
   function automatic verdict_type lookup_name();
      logic [eba_pkg::KEY_WIDTH-1:0] lo;
      logic [eba_pkg::KEY_WIDTH-1:0] hi;
      logic                          hit;
      lo  = '0;
      hi  = '0;
      hit = 1'b0;
      for (int i = 0; i < 8; i++) lo[8*i +: 8] = name_buf[i];
      for (int i = 8; i < eba_pkg::NAME_STORE; i++) hi[8*(i-8) +: 8] = name_buf[i];
      for (int s = 0; s < eba_pkg::SLOT_STORE && s < TABLE_ENTRIES; s++) begin
         if (slot_used[s] && key_lo[s] == lo && key_hi[s] == hi) hit = 1'b1;
      end
      return '{allowed: hit, name_length: name_len};
   endfunction

   // One accepted request: table write, terminator or name byte
   task automatic apply_request();
      logic [7:0] c;
      c = req_mon.path_char;
      if (req_mon.kind == eba_pkg::KIND_SLOT_WRITE) begin
         if (int'(req_mon.entry_slot) < TABLE_ENTRIES) begin
            key_lo[req_mon.entry_slot]    = req_mon.entry_low;
            key_hi[req_mon.entry_slot]    = req_mon.entry_high;
            slot_used[req_mon.entry_slot] = req_mon.entry_valid;
         end
      end else if (c == eba_pkg::CHAR_NUL) begin
         verdicts_due.push_back(lookup_name());
         clear_name();
         path_pos = '0;
      end else begin
         if (c == eba_pkg::CHAR_SLASH && int'(path_pos) < SLASH_SCAN_LIMIT) begin
            // early slash starts a new basename
            clear_name();
         end else if (int'(name_len) < NAME_MAX_BYTES) begin
            if (c >= eba_pkg::CHAR_UPPER_A && c <= eba_pkg::CHAR_UPPER_Z)
               c = c + eba_pkg::CASE_OFFSET;
            name_buf[name_len] = c;
            name_len           = name_len + 1'b1;
         end
         // position saturates at the scan limit
         if (int'(path_pos) < SLASH_SCAN_LIMIT) path_pos = path_pos + 1'b1;
      end
   endtask

   task automatic flag_verdict(input string what, input verdict_type want,
                               input verdict_type seen);
      failures++;
      if (failures <= MAX_REPORTS)
         $display("%0d ns: %s: expected allowed=%0d length=%0d, got allowed=%0d length=%0d",
                  $time, what, want.allowed, want.name_length, seen.allowed,
                  seen.name_length);
   endtask

   // Compare responses first, then fold in the request of the same edge
   always @(posedge clock) begin
      verdict_type seen;
      verdict_type want;
      if (reset) begin
         clear_name();
         path_pos = '0;
         for (int s = 0; s < eba_pkg::SLOT_STORE; s++) begin
            key_lo[s]    = '0;
            key_hi[s]    = '0;
            slot_used[s] = 1'b0;
         end
         verdicts_due.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = '{allowed: rsp_mon.allowed, name_length: rsp_mon.name_length};
            verdicts_checked++;
            if (seen.allowed) verdicts_allowed++;
            if (verdicts_due.size() == 0) begin
               flag_verdict("verdict with none pending", '0, seen);
            end else begin
               want = verdicts_due.pop_front();
               if (seen.allowed !== want.allowed)
                  flag_verdict("allowed mismatch", want, seen);
               else if (seen.name_length !== want.name_length)
                  flag_verdict("name_length mismatch", want, seen);
            end
         end
         if (req_mon.valid && req_mon.ready) apply_request();
      end
      verdicts_pending <= verdicts_due.size();
   end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives program paths and allowlist writes into the basename allowlist check,
// with random idling on both channels, a long response hold-off and a drain
// pause; the verdict checker predicts and compares every response.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 400000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 100;   // chain depth plus margin
   localparam int POOL_SIZE    = 8;
   localparam int SLASH_SCAN_LIMIT_DEFAULT = 256;
   localparam string NAME_CHARS = "abcdefghijklmnopqrstuvwxyz0123456789._-";

   logic clock;
   logic reset;

   eba_req_if req_bus ();
   eba_rsp_if rsp_bus ();

   int failures;
   int verdicts_pending;
   int verdicts_checked;
   int verdicts_allowed;
   int requests_sent;
   int slot_writes;
   int cycle_count;
   int holdoffs_asked;
   int holdoffs_done;
   bit req_idle_on;
   bit rsp_idle_on;

   string pool_names[POOL_SIZE];

   exec_basename_allowlist_check dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   eba_verdict_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .failures         (failures),
      .verdicts_pending (verdicts_pending),
      .verdicts_checked (verdicts_checked),
      .verdicts_allowed (verdicts_allowed)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[exec_basename_allowlist_check] ERROR");
      $finish;
   end

   // Response side: random stalls, plus long hold-offs on request
   initial begin
      int hold_count;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoffs_done < holdoffs_asked) begin
            holdoffs_done++;
            rsp_bus.ready <= 1'b0;
            hold_count = 0;
            while (hold_count < HOLD_CYCLES) begin
               @(negedge clock);
               hold_count++;
            end
         end else if (!rsp_idle_on || $urandom_range(0, 99) >= 35) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b0;
         end
      end
   end

   // Name text to a 16-byte key, byte 0 in the low bits
   function automatic logic [127:0] text_key(input string s);
      logic [127:0] key;
      key = '0;
      for (int i = 0; i < s.len() && i < 16; i++) key[8*i +: 8] = s[i];
      return key;
   endfunction

   function automatic logic [7:0] rand_name_byte();
      logic [7:0] c;
      c = 8'($urandom_range(1, 255));
      while (c == eba_pkg::CHAR_SLASH) c = 8'($urandom_range(1, 255));
      return c;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(input logic kind, input logic [7:0] ch,
                               input logic [eba_pkg::SLOT_WIDTH-1:0] slot,
                               input logic [127:0] key, input logic in_use);
      while (req_idle_on && $urandom_range(0, 99) < 35) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.kind        <= kind;
      req_bus.path_char   <= ch;
      req_bus.entry_slot  <= slot;
      req_bus.entry_low   <= key[63:0];
      req_bus.entry_high  <= key[127:64];
      req_bus.entry_valid <= in_use;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      requests_sent++;
   endtask

   // Path byte; the unused fields carry noise
   task automatic send_byte(input logic [7:0] ch);
      send_request(eba_pkg::KIND_PATH_BYTE, ch,
                   eba_pkg::SLOT_WIDTH'($urandom_range(0, 63)),
                   {$urandom, $urandom, $urandom, $urandom}, 1'($urandom_range(0, 1)));
   endtask

   task automatic send_write(input logic [eba_pkg::SLOT_WIDTH-1:0] slot,
                             input logic [127:0] key, input logic in_use);
      send_request(eba_pkg::KIND_SLOT_WRITE, 8'($urandom_range(0, 255)), slot, key, in_use);
      slot_writes++;
   endtask

   // Name text, optionally with random letters raised to upper case
   task automatic send_text(input string s, input bit mix_case);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if (mix_case && c >= "a" && c <= "z" && $urandom_range(0, 1))
            c = c - eba_pkg::CASE_OFFSET;
         send_byte(c);
      end
   endtask

   task automatic send_random_write();
      logic [127:0] key;
      int           pick;
      pick = $urandom_range(0, 99);
      key  = text_key(pool_names[$urandom_range(0, POOL_SIZE - 1)]);
      if (pick >= 90) begin
         key = {$urandom, $urandom, $urandom, $urandom};
      end else if (pick >= 75) begin
         // last key byte set: this slot can never match
         key[127:120] = 8'($urandom_range(1, 255));
      end
      send_write(eba_pkg::SLOT_WIDTH'($urandom_range(0, 63)), key,
                 $urandom_range(0, 99) < 80);
   endtask

   // Directories, sometimes interleaved with table writes, then a basename
   task automatic send_random_path();
      int dirs;
      int pick;
      int len;
      dirs = $urandom_range(0, 3);
      for (int d = 0; d < dirs; d++) begin
         if ($urandom_range(0, 3) == 0) send_byte(eba_pkg::CHAR_SLASH);
         len = $urandom_range(0, 5);
         repeat (len) send_byte(rand_name_byte());
         send_byte(eba_pkg::CHAR_SLASH);
         if ($urandom_range(0, 9) == 0) send_random_write();
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         send_text(pool_names[$urandom_range(0, POOL_SIZE - 1)], 1'b1);
      end else if (pick < 80) begin
         // raw bytes, slashes included
         len = $urandom_range(0, 12);
         repeat (len) send_byte(8'($urandom_range(1, 255)));
      end else begin
         // name with extra bytes appended: any beyond the buffer are dropped
         send_text(pool_names[$urandom_range(0, POOL_SIZE - 1)], 1'b1);
         len = $urandom_range(1, 16);
         repeat (len) send_byte(rand_name_byte());
      end
      send_byte(eba_pkg::CHAR_NUL);
   endtask

   task automatic run_random(input int count);
      int stop_at;
      stop_at = requests_sent + count;
      while (requests_sent < stop_at) begin
         if ($urandom_range(0, 99) < 15) send_random_write();
         else send_random_path();
      end
   endtask

   task automatic wait_drained();
      while (verdicts_pending != 0) @(negedge clock);
   endtask

   // Stimulus
   initial begin
      int           len;
      string        s;
      logic [127:0] ones_key;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.kind        = eba_pkg::KIND_PATH_BYTE;
      req_bus.path_char   = eba_pkg::CHAR_NUL;
      req_bus.entry_slot  = '0;
      req_bus.entry_low   = '0;
      req_bus.entry_high  = '0;
      req_bus.entry_valid = 1'b0;
      req_idle_on         = 1'b1;
      rsp_idle_on         = 1'b1;
      holdoffs_asked      = 0;
      holdoffs_done       = 0;
      requests_sent       = 0;
      slot_writes         = 0;
      ones_key            = '1;

      // Name pool: empty, full length, and assorted lengths
      for (int p = 0; p < POOL_SIZE; p++) begin
         s   = "";
         len = (p == 0) ? 0 : (p == 1) ? eba_pkg::NAME_STORE :
               $urandom_range(1, eba_pkg::NAME_STORE - 1);
         repeat (len)
            s = $sformatf("%s%c", s, NAME_CHARS[$urandom_range(0, NAME_CHARS.len() - 1)]);
         pool_names[p] = s;
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: table extremes, case folding, empty names
      send_write('0, text_key("ls"), 1'b1);
      send_write('1, ones_key, 1'b1);
      send_write(eba_pkg::SLOT_WIDTH'(1), '0, 1'b1);
      send_text("/BIN/LS", 1'b0);
      send_byte(eba_pkg::CHAR_NUL);
      send_byte(eba_pkg::CHAR_NUL);
      send_write(eba_pkg::SLOT_WIDTH'(1), '0, 1'b0);
      send_byte(eba_pkg::CHAR_SLASH);
      send_byte(eba_pkg::CHAR_NUL);
      send_text("AZ@[", 1'b0);
      send_byte(8'hFF);
      send_byte(eba_pkg::CHAR_NUL);

      // Random with idling, then a stretch without
      run_random(200);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      run_random(100);

      // Hold responses off while short paths keep coming, then drain
      holdoffs_asked++;
      repeat (50) begin
         if ($urandom_range(0, 1)) send_byte(8'($urandom_range(1, 255)));
         send_byte(eba_pkg::CHAR_NUL);
      end
      req_bus.valid <= 1'b0;
      wait_drained();

      // Late slash: the slash at position 255 clears, the one at 256 is kept
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      send_write(eba_pkg::SLOT_WIDTH'($urandom_range(0, 63)), text_key("/ab"), 1'b1);
      repeat (SLASH_SCAN_LIMIT_DEFAULT - 1) send_byte(rand_name_byte());
      send_byte(eba_pkg::CHAR_SLASH);
      send_byte(eba_pkg::CHAR_SLASH);
      send_text("ab", 1'b0);
      send_byte(eba_pkg::CHAR_NUL);

      run_random(120);
      req_bus.valid <= 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Run covered %0d requests, %0d of them table writes; %0d verdicts, %0d allowed.",
               requests_sent, slot_writes, verdicts_checked, verdicts_allowed);
      $display("Included a %0d-cycle response hold-off, a late slash and truncated names.",
               HOLD_CYCLES);
      if (failures == 0 && verdicts_pending == 0) begin
         $display("[exec_basename_allowlist_check] OK");
      end else begin
         $display("[exec_basename_allowlist_check] ERROR");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/eba_pkg.sv
hdl/eba_if.sv
hdl/eba_name_collect.sv
hdl/eba_cell.sv
hdl/exec_basename_allowlist_check.sv
tb/sv/eba_verdict_checker.sv
tb/sv/testbench.sv
